FILE: hw/rtl/lbpg_pkg.sv
// Package for the LED blink pattern generator.
// Holds mode codes, register indexes, widths and reset values; no dependencies.
`default_nettype none

package lbpg_pkg;

    localparam int CNT_W    = 16;
    localparam int FLASH_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] FLASH_TICKS = CNT_W'(200);
    localparam logic [CNT_W-1:0] PAUSE_TICKS = CNT_W'(1000);

    localparam logic [CNT_W-1:0]   ON_TICKS_RST     = CNT_W'(500);
    localparam logic [CNT_W-1:0]   OFF_TICKS_RST    = CNT_W'(500);
    localparam logic [FLASH_W-1:0] BLINK_TARGET_RST = '0;

    typedef enum logic [1:0] {
        MODE_DARK  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_BURST = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_SELECT  = 2'd0,
        REG_ON_TICKS     = 2'd1,
        REG_OFF_TICKS    = 2'd2,
        REG_BLINK_TARGET = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_blink_pattern_generator_core.sv
// LED blink pattern generator top level: tick requests in, LED level and
// burst-complete flag out. Depends on lbpg_pkg.
// The result is registered for the cycle after a request is taken. One request
// per cycle while out_ready keeps up, set by the single increment-compare-update on the pattern counters.
// Reset: async active low; pattern state cleared, registers to defaults
// (off mode, 500/500 ticks, zero target), no result pending.
`default_nettype none

module led_blink_pattern_generator_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             tick_pulse,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  led_on,
    output logic                                  burst_done,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lbpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lbpg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lbpg_pkg::mode_t                     mode_reg, mode_next;
    logic [lbpg_pkg::CNT_W-1:0]          on_ticks_reg, on_ticks_next;
    logic [lbpg_pkg::CNT_W-1:0]          off_ticks_reg, off_ticks_next;
    logic [lbpg_pkg::FLASH_W-1:0]        target_reg, target_next;
    logic                                lit_reg, lit_next;
    logic [lbpg_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [lbpg_pkg::FLASH_W-1:0]        flashes_reg, flashes_next;
    logic                                pause_reg, pause_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                led_reg, led_next;
    logic                                done_reg, done_next;

    logic                                in_take;
    logic                                cfg_take;
    logic [lbpg_pkg::CNT_W-1:0]          limit;
    logic [lbpg_pkg::CNT_W:0]            count_inc;
    logic                                wrap;
    logic [lbpg_pkg::FLASH_W-1:0]        flashes_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign cfg_take  = cfg_valid && cfg_ready;

    assign out_valid  = out_valid_reg;
    assign led_on     = led_reg;
    assign burst_done = done_reg;

    always_comb
    begin
        if (mode_reg == lbpg_pkg::MODE_BLINK)
        begin
            limit = lit_reg ? on_ticks_reg : off_ticks_reg;
        end
        else if (pause_reg)
        begin
            limit = lbpg_pkg::PAUSE_TICKS;
        end
        else
        begin
            limit = lbpg_pkg::FLASH_TICKS;
        end
    end

    assign count_inc   = {1'b0, count_reg} + (lbpg_pkg::CNT_W+1)'(1);
    assign wrap        = count_inc >= {1'b0, limit};
    assign flashes_inc = flashes_reg + lbpg_pkg::FLASH_W'(1);

    always_comb
    begin
        mode_next      = mode_reg;
        on_ticks_next  = on_ticks_reg;
        off_ticks_next = off_ticks_reg;
        target_next    = target_reg;
        lit_next       = lit_reg;
        count_next     = count_reg;
        flashes_next   = flashes_reg;
        pause_next     = pause_reg;

        if (in_take && tick_pulse)
        begin
            unique case (mode_reg)
                lbpg_pkg::MODE_DARK:
                begin
                    lit_next = 1'b0;
                end
                lbpg_pkg::MODE_ON:
                begin
                    lit_next = 1'b1;
                end
                lbpg_pkg::MODE_BLINK:
                begin
                    count_next = wrap ? '0 : count_inc[lbpg_pkg::CNT_W-1:0];
                    if (wrap)
                    begin
                        lit_next = !lit_reg;
                    end
                end
                default:
                begin
                    count_next = wrap ? '0 : count_inc[lbpg_pkg::CNT_W-1:0];
                    if (wrap)
                    begin
                        if (pause_reg)
                        begin
                            pause_next   = 1'b0;
                            flashes_next = '0;
                        end
                        else if (lit_reg)
                        begin
                            lit_next     = 1'b0;
                            flashes_next = flashes_inc;
                            if (flashes_inc >= target_reg)
                            begin
                                pause_next = 1'b1;
                            end
                        end
                        else
                        begin
                            lit_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (cfg_take)
        begin
            unique case (lbpg_pkg::reg_idx_t'(cfg_index))
                lbpg_pkg::REG_MODE_SELECT:
                begin
                    mode_next    = lbpg_pkg::mode_t'(cfg_data[1:0]);
                    count_next   = '0;
                    flashes_next = '0;
                    pause_next   = 1'b0;
                    lit_next     = (lbpg_pkg::mode_t'(cfg_data[1:0]) == lbpg_pkg::MODE_ON);
                end
                lbpg_pkg::REG_ON_TICKS:
                begin
                    on_ticks_next = cfg_data;
                end
                lbpg_pkg::REG_OFF_TICKS:
                begin
                    off_ticks_next = cfg_data;
                end
                lbpg_pkg::REG_BLINK_TARGET:
                begin
                    target_next = cfg_data[lbpg_pkg::FLASH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        led_next       = led_reg;
        done_next      = done_reg;
        if (in_take)
        begin
            out_valid_next = 1'b1;
            led_next       = lit_next;
            done_next      = pause_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lbpg_pkg::MODE_DARK;
            on_ticks_reg  <= lbpg_pkg::ON_TICKS_RST;
            off_ticks_reg <= lbpg_pkg::OFF_TICKS_RST;
            target_reg    <= lbpg_pkg::BLINK_TARGET_RST;
            lit_reg       <= 1'b0;
            count_reg     <= '0;
            flashes_reg   <= '0;
            pause_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            on_ticks_reg  <= on_ticks_next;
            off_ticks_reg <= off_ticks_next;
            target_reg    <= target_next;
            lit_reg       <= lit_next;
            count_reg     <= count_next;
            flashes_reg   <= flashes_next;
            pause_reg     <= pause_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        led_reg  <= led_next;
        done_reg <= done_next;
    end

endmodule

`default_nettype wire
